>>> rtl/aip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser package
// Character constants, the byte classification record and the result record
// shared by the classifier, the parse core and the top level.
// ----------------------------------------------------------------------------
package aip_pkg;

    // Width of the result value on the output stream.
    localparam int RESULT_BITS = 32;

    // Character codes used by the grammar.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Classification of one text byte.
    typedef struct packed {
        logic       is_nul;
        logic       is_ws;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_dec;
        logic       is_x;
        logic       is_hex;
        logic [3:0] digit;
    } t_char_class;

    // Result of one string, formed when its terminating NUL is processed.
    typedef struct packed {
        logic                   is_valid;
        logic [RESULT_BITS-1:0] value;
    } t_result;

endpackage : aip_pkg
`default_nettype wire

>>> rtl/ascii_integer_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser
// Checks and converts a NUL-terminated decimal or 0x-prefixed hex integer
// streamed one byte per request, and returns a valid flag and value per string.
// ----------------------------------------------------------------------------
// Path: a string's result is loaded into the result register when its NUL
// byte leaves the input register (input register, then result register).
// Throughput: one byte per cycle; the input register advances every cycle
// unless a NUL byte meets a finished result held by the downstream side.
// Reset: synchronous, active low; empties both registers and returns the
// parser to the leading whitespace phase with a cleared accumulator.
module ascii_integer_parser
    import aip_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream.
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [7:0]             i_s_tdata,   // [7:0] char_code
    // Result stream.
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [RESULT_BITS-1:0]      o_m_tdata,   // [31:0] parsed_value
    output logic                        o_m_tuser    // [0] is_valid
);

    logic                   r_in_vld;
    logic [7:0]             r_in_char;
    logic                   r_out_vld;
    logic                   r_out_flag;
    logic [RESULT_BITS-1:0] r_out_value;

    t_char_class            char_class;
    t_result                result;
    logic                   advance;
    logic                   load_out;

    // The held byte moves on unless it ends a string and the result slot is full.
    assign advance    = r_in_vld && (!char_class.is_nul || !r_out_vld || i_m_tready);
    assign load_out   = advance && char_class.is_nul;
    assign o_s_tready = !r_in_vld || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
        end
    end

    aip_char_class u_char_class (
        .i_char  (r_in_char),
        .o_class (char_class)
    );

    aip_parse_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_class  (char_class),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_flag  <= result.is_valid;
            r_out_value <= result.value;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_flag;

    // An invalid string always reports a zero value.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_flag |-> r_out_value == '0)
        else $error("invalid result carries a nonzero value");

    // A held byte that cannot move keeps its place and value.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_char))
        else $error("stalled input byte lost or changed");

    // A new result is loaded only when the previous one is gone or leaving.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !r_out_vld || i_m_tready)
        else $error("pending result overwritten");

endmodule : ascii_integer_parser
`default_nettype wire

>>> rtl/aip_char_class.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser character classifier
// Decodes one registered text byte into the flags and digit value used by
// the parse core.
// ----------------------------------------------------------------------------
module aip_char_class
    import aip_pkg::*;
(
    input  wire logic [7:0]  i_char,
    output t_char_class      o_class
);

    logic [7:0] lower_char;
    logic       dec_hit;
    logic       alpha_hit;

    // Fold letters to lower case for the hex letters and the x of the prefix.
    assign lower_char = i_char | CASE_BIT;
    assign dec_hit    = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign alpha_hit  = (lower_char >= CH_LC_A) && (lower_char <= CH_LC_F);

    // Flags and digit value.
    always_comb begin
        o_class.is_nul   = (i_char == CH_NUL);
        o_class.is_ws    = (i_char == CH_SPACE) || (i_char == CH_TAB) ||
                           (i_char == CH_LF) || (i_char == CH_CR);
        o_class.is_sign  = (i_char == CH_PLUS) || (i_char == CH_MINUS);
        o_class.is_minus = (i_char == CH_MINUS);
        o_class.is_zero  = (i_char == CH_ZERO);
        o_class.is_dec   = dec_hit;
        o_class.is_x     = (lower_char == CH_LC_X);
        o_class.is_hex   = dec_hit || alpha_hit;
        if (dec_hit) begin
            o_class.digit = 4'(i_char - CH_ZERO);
        end else begin
            o_class.digit = 4'(lower_char - CH_LC_A + 8'd10);
        end
    end

endmodule : aip_char_class
`default_nettype wire

>>> rtl/aip_parse_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser core
// Holds the grammar phase, the sign and the accumulator, advances them by one
// classified byte per step and forms the result for the terminating NUL.
// ----------------------------------------------------------------------------
module aip_parse_core
    import aip_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire t_char_class i_class,
    output t_result          o_result
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_ZERO,
        PH_HEXPFX,
        PH_HEX,
        PH_DEC,
        PH_TRAIL,
        PH_ERR
    } t_phase;

    t_phase                r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_acc, n_acc;

    logic [VALUE_BITS-1:0] digit_ext;
    logic [VALUE_BITS-1:0] acc_dec;
    logic [VALUE_BITS-1:0] acc_hex;
    logic [VALUE_BITS-1:0] signed_acc;

    // Multiply-add by the radix as shifts and adds.
    assign digit_ext = {{(VALUE_BITS-4){1'b0}}, i_class.digit};
    assign acc_dec   = (r_acc << 3) + (r_acc << 1) + digit_ext;
    assign acc_hex   = (r_acc << 4) + digit_ext;

    // Next phase, sign and accumulator for the current byte.
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (i_class.is_nul) begin
            n_phase = PH_LEAD;
            n_neg   = 1'b0;
            n_acc   = '0;
        end else begin
            case (r_phase)
                PH_LEAD: begin
                    if (i_class.is_ws) begin
                        n_phase = PH_LEAD;
                    end else if (i_class.is_sign) begin
                        n_neg   = i_class.is_minus;
                        n_phase = PH_SIGN;
                    end else if (i_class.is_zero) begin
                        n_acc   = '0;
                        n_phase = PH_ZERO;
                    end else if (i_class.is_dec) begin
                        n_acc   = digit_ext;
                        n_phase = PH_DEC;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_SIGN: begin
                    if (i_class.is_dec) begin
                        n_acc   = digit_ext;
                        n_phase = PH_DEC;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_ZERO: begin
                    if (i_class.is_x) begin
                        n_phase = PH_HEXPFX;
                    end else if (i_class.is_dec) begin
                        n_acc   = acc_dec;
                        n_phase = PH_DEC;
                    end else if (i_class.is_ws) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_HEXPFX, PH_HEX: begin
                    if (i_class.is_hex) begin
                        n_acc   = acc_hex;
                        n_phase = PH_HEX;
                    end else if (r_phase == PH_HEX && i_class.is_ws) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_DEC: begin
                    if (i_class.is_dec) begin
                        n_acc = acc_dec;
                    end else if (i_class.is_ws) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_TRAIL: begin
                    if (!i_class.is_ws) begin
                        n_phase = PH_ERR;
                    end
                end
                default: begin
                    n_phase = PH_ERR;
                end
            endcase
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    // Result of the string ending with the current byte.
    assign signed_acc        = r_neg ? ({VALUE_BITS{1'b0}} - r_acc) : r_acc;
    assign o_result.is_valid = r_phase inside {PH_ZERO, PH_HEX, PH_DEC, PH_TRAIL};

    generate
        if (VALUE_BITS >= RESULT_BITS) begin : g_trunc
            assign o_result.value = o_result.is_valid ?
                                    signed_acc[RESULT_BITS-1:0] : '0;
        end else begin : g_ext
            assign o_result.value = o_result.is_valid ?
                                    {{(RESULT_BITS-VALUE_BITS){1'b0}}, signed_acc} : '0;
        end
    endgenerate

    // A NUL byte always returns the parser to its start state.
    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_class.is_nul |=> r_phase == PH_LEAD && !r_neg && r_acc == '0)
        else $error("parse state not cleared after end of string");

    // The error phase is left only through a NUL byte.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_ERR && !i_class.is_nul |=> r_phase == PH_ERR)
        else $error("error phase left before end of string");

endmodule : aip_parse_core
`default_nettype wire
